### sv/cdb_pkg.sv
// ----------------------------------------------------------------------------
// cdb_pkg
// Shared constants, types and helpers for the circular deque buffer.
// ----------------------------------------------------------------------------
package cdb_pkg;

   localparam int DEPTH       = 16;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CAP_W       = 5;
   localparam int DATA_W      = 32;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 104;

   localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_PUSH_REAR = 2'd0,
      OP_POP_FRONT = 2'd1,
      OP_POP_REAR  = 2'd2,
      OP_STATUS    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_PEEK = 2'd2,
      ST_LOAD = 2'd3
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic peek;
      logic load_rsp;
   } cmd_type;

   // zero reads as one, anything above the built depth as the depth
   function automatic logic [CAP_W-1:0] clamp_capacity(input logic [CAP_W-1:0] v);
      logic [CAP_W-1:0] r;
      if (v == '0) begin
         r = CAP_W'(1);
      end else if (v > CAP_MAX) begin
         r = CAP_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### sv/cdb_ctrl.sv
// ----------------------------------------------------------------------------
// cdb_ctrl
// Sequencer: takes an item, steps it through update, peek and result load,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module cdb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output cdb_pkg::cmd_type cmd
);
   import cdb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_PEEK;
         end
         ST_PEEK: begin
            cmd.peek = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // wait here while the previous result is still held
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_load_frees_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken result");

   a_exec_after_capture: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec)
      else $error("captured item not executed next cycle");

endmodule

### sv/cdb_datapath.sv
// ----------------------------------------------------------------------------
// cdb_datapath
// Ring pointers, entry memory with two registered read ports, and the
// result register.
// ----------------------------------------------------------------------------
module cdb_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  cdb_pkg::cmd_type                 cmd,
   input  logic [1:0]                       req_opcode,
   input  logic [cdb_pkg::DATA_W-1:0]       req_value,
   input  logic                             csr_wr_en,
   input  logic [cdb_pkg::CAP_W-1:0]        csr_wr_data,
   output logic                             rsp_status,
   output logic [cdb_pkg::RSP_TDATA_W-1:0]  rsp_payload
);
   import cdb_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];

   opcode_type        op_ff;
   logic [DATA_W-1:0] wv_ff;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [ADDR_W-1:0] front_ff, front_in;
   logic [ADDR_W-1:0] rear_ff, rear_in;
   logic [CAP_W-1:0]  count_ff, count_in;
   logic              status_ff, status_in;
   logic              popped_ff, popped_in;
   logic [DATA_W-1:0] pop_data_ff;
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic              rsp_status_ff;
   logic [DATA_W-1:0] rsp_read_ff, rsp_front_ff, rsp_rear_ff;
   logic              rsp_full_ff, rsp_empty_ff;
   logic [CAP_W-1:0]  rsp_count_ff;

   logic [ADDR_W-1:0] front_inc, rear_inc, rear_dec;
   logic [ADDR_W-1:0] rd_a_addr;
   logic              rd_a_en;
   logic              mem_we;
   logic [CAP_W-1:0]  cap_new;

   always_comb begin
      front_inc = ((CAP_W'(front_ff) + CAP_W'(1)) == cap_ff) ? '0 : front_ff + ADDR_W'(1);
      rear_inc  = ((CAP_W'(rear_ff) + CAP_W'(1)) == cap_ff) ? '0 : rear_ff + ADDR_W'(1);
      rear_dec  = (rear_ff == '0) ? ADDR_W'(cap_ff - CAP_W'(1)) : rear_ff - ADDR_W'(1);
      cap_new   = clamp_capacity(csr_wr_data);
   end

   always_comb begin
      cap_in    = cap_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      count_in  = count_ff;
      status_in = status_ff;
      popped_in = popped_ff;
      mem_we    = 1'b0;
      if (csr_wr_en) begin
         cap_in   = cap_new;
         front_in = '0;
         rear_in  = ADDR_W'(cap_new - CAP_W'(1));
         count_in = '0;
      end else if (cmd.exec) begin
         status_in = 1'b0;
         popped_in = 1'b0;
         unique case (op_ff)
            OP_PUSH_REAR: begin
               if (count_ff == cap_ff) begin
                  status_in = 1'b1;
               end else begin
                  mem_we   = 1'b1;
                  rear_in  = rear_inc;
                  count_in = count_ff + CAP_W'(1);
               end
            end
            OP_POP_FRONT: begin
               if (count_ff == '0) begin
                  status_in = 1'b1;
               end else begin
                  popped_in = 1'b1;
                  front_in  = front_inc;
                  count_in  = count_ff - CAP_W'(1);
               end
            end
            OP_POP_REAR: begin
               if (count_ff == '0) begin
                  status_in = 1'b1;
               end else begin
                  popped_in = 1'b1;
                  rear_in   = rear_dec;
                  count_in  = count_ff - CAP_W'(1);
               end
            end
            OP_STATUS: begin
            end
            default: begin
            end
         endcase
      end
   end

   // port A: popped word during update, front peek afterwards
   always_comb begin
      rd_a_en   = cmd.exec | cmd.peek;
      rd_a_addr = (cmd.exec && op_ff == OP_POP_REAR) ? rear_ff : front_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[rear_inc] <= wv_ff;
      end
      if (rd_a_en) begin
         rd_a_ff <= mem[rd_a_addr];
      end
      if (cmd.peek) begin
         rd_b_ff <= mem[rear_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= clamp_capacity(CAP_RESET);
         front_ff <= '0;
         rear_ff  <= ADDR_W'(clamp_capacity(CAP_RESET) - CAP_W'(1));
         count_ff <= '0;
      end else begin
         cap_ff   <= cap_in;
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      popped_ff <= popped_in;
      if (cmd.capture) begin
         op_ff <= opcode_type'(req_opcode);
         wv_ff <= req_value;
      end
      if (cmd.peek) begin
         pop_data_ff <= rd_a_ff;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_read_ff   <= popped_ff ? pop_data_ff : '0;
         rsp_full_ff   <= (count_ff == cap_ff);
         rsp_empty_ff  <= (count_ff == '0);
         rsp_count_ff  <= count_ff;
         rsp_front_ff  <= (count_ff == '0) ? '0 : rd_a_ff;
         rsp_rear_ff   <= (count_ff == '0) ? '0 : rd_b_ff;
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_payload = {1'b0, rsp_rear_ff, rsp_front_ff, rsp_count_ff,
                         rsp_empty_ff, rsp_full_ff, rsp_read_ff};

   a_count_le_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("entry count above capacity");

   a_front_in_ring: assert property (@(posedge clock) disable iff (reset)
      CAP_W'(front_ff) < cap_ff)
      else $error("front index outside the ring");

   a_rear_in_ring: assert property (@(posedge clock) disable iff (reset)
      CAP_W'(rear_ff) < cap_ff)
      else $error("rear index outside the ring");

   a_pop_empty_refused: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !csr_wr_en && (op_ff == OP_POP_FRONT || op_ff == OP_POP_REAR)
       && count_ff == '0) |=> (status_ff && !popped_ff))
      else $error("pop on empty buffer not refused");

endmodule

### sv/circular_deque_buffer.sv
// ----------------------------------------------------------------------------
// circular_deque_buffer
// Ring-buffer deque of signed 32-bit words with a programmable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser carries the opcode (push rear, pop front, pop rear,
//   status), tdata the word to push. Every item yields exactly one item on
//   the rsp channel: tuser is the refused flag, tdata the popped word, the
//   full/empty flags, the count and front/rear peeks (zero when empty).
//   The sequencer steps each item through capture, update, peek and load
//   around the single-write, two-read entry memory, and takes a new item
//   only once the previous one is loaded into the result register.
//   A finished result sits in the output register; the next item is taken
//   and worked meanwhile, and waits in its load step while rsp is stalled.
//   csr_wr_en writes the capacity (0 reads as 1, above 16 as 16) and
//   empties the buffer; write it only while no item is in flight.
//   Reset: capacity 16, buffer empty, no result pending, no clearing pass.
// ----------------------------------------------------------------------------
module circular_deque_buffer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cdb_pkg::REQ_TDATA_W-1:0]     req_tdata,  // [31:0] write_value
   input  logic [1:0]                          req_tuser,  // [1:0] opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] read_value, [32] is_full, [33] is_empty, [38:34] entry_count,
   // [70:39] front_value, [102:71] rear_value, [103] zero
   output logic [cdb_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,  // [0] status
   input  logic                                csr_wr_en,
   input  logic [cdb_pkg::CAP_W-1:0]           csr_wr_data // queue_capacity
);
   import cdb_pkg::*;

   cmd_type cmd;

   cdb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   cdb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_opcode  (req_tuser),
      .req_value   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_status  (rsp_tuser),
      .rsp_payload (rsp_tdata)
   );

endmodule
